>>> hw/rtl/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg
// shared constants, register indexes and the arctangent table of the
// space-vector pwm compare generator
// ----------------------------------------------------------------------------
package svc_pkg;

   // number formats
   localparam int FIELD_BITS    = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD_BITS    = 8;
   localparam int XY_BITS       = FIELD_BITS + GUARD_BITS + 3;
   localparam int Z_BITS        = 32;
   localparam int LEN_BITS      = 16;
   localparam int M_BITS        = XY_BITS - 1 + 30 - 30 - GUARD_BITS;
   localparam int SIX_BITS      = ANGLE_BITS + 3;

   // inverse cordic gain, q0.30
   localparam logic [29:0] INV_GAIN = 30'd652032874;
   localparam logic [LEN_BITS-1:0] FULL_LEN = LEN_BITS'(32768);

   // phase high patterns, one bit per sector
   localparam logic [5:0] HIGH_A = 6'b100011;
   localparam logic [5:0] HIGH_B = 6'b001110;
   localparam logic [5:0] HIGH_C = 6'b111000;
   localparam logic [2:0] LAST_SECTOR = 3'd5;

   // operation codes
   localparam logic OP_ROTATE = 1'b0;
   localparam logic OP_DIRECT = 1'b1;

   // register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_D_DEMAND   = 2'd0;
   localparam csr_index_type CSR_Q_DEMAND   = 2'd1;
   localparam csr_index_type CSR_PWM_PERIOD = 2'd2;

   localparam logic [15:0] PERIOD_RESET = 16'd35999;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [Z_BITS-1:0] atan_turn(input int i);
      logic [Z_BITS-1:0] v;
      case (i)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> hw/rtl/svpwm_compare_generator.sv
// ----------------------------------------------------------------------------
// svpwm_compare_generator
// space-vector pwm compare generator with inverse park rotation
// ----------------------------------------------------------------------------
// req channel: operation selects rotation of the d/q demand by rotor_angle
// or use of vec_alpha/vec_beta directly. rsp channel: one transfer of three
// phase compare values per request transfer, in request order.
// csr port: csr_write with csr_index 0 d demand, 1 q demand, 2 pwm period;
// other indexes are ignored. write only while no request is in flight.
// pipeline: 21 register stages (one operand stage, 16 cordic iteration
// stages, four scaling and compare stages).
// throughput: one transfer per cycle unless stalled; every stage is a
// register and the cordic has a stage of its own for each iteration.
// stall: the whole pipeline holds while rsp_valid is high and rsp_ready
// low, so req_ready drops with it; nothing is lost or repeated.
// reset: all stage valid bits clear, the demands return to zero and the
// period to 35999 ticks.
// ----------------------------------------------------------------------------
module svpwm_compare_generator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [15:0]                 req_rotor_angle,
   input  logic signed [15:0]          req_vec_alpha,
   input  logic signed [15:0]          req_vec_beta,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [15:0]                 rsp_compare_a,
   output logic [15:0]                 rsp_compare_b,
   output logic [15:0]                 rsp_compare_c,
   input  logic                        csr_write,
   input  svc_pkg::csr_index_type      csr_index,
   input  logic [15:0]                 csr_wdata
);
   import svc_pkg::*;

   logic signed [15:0] d_demand_ff;
   logic signed [15:0] q_demand_ff;
   logic [15:0]        pwm_period_ff;
   logic               pipe_en;
   logic               cordic_valid;
   logic signed [XY_BITS-1:0] cordic_x;
   logic [Z_BITS-1:0]  cordic_z;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         d_demand_ff   <= '0;
         q_demand_ff   <= '0;
         pwm_period_ff <= PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_D_DEMAND:   d_demand_ff   <= csr_wdata;
            CSR_Q_DEMAND:   q_demand_ff   <= csr_wdata;
            CSR_PWM_PERIOD: pwm_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advances unless a finished result is held
   assign pipe_en   = !rsp_valid || rsp_ready;
   assign req_ready = pipe_en;

   svc_cordic u_cordic (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_valid    (req_valid),
      .operation   (req_operation),
      .rotor_angle (req_rotor_angle),
      .vec_alpha   (req_vec_alpha),
      .vec_beta    (req_vec_beta),
      .d_demand    (d_demand_ff),
      .q_demand    (q_demand_ff),
      .out_valid   (cordic_valid),
      .out_x       (cordic_x),
      .out_z       (cordic_z)
   );

   svc_timing u_timing (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_valid   (cordic_valid),
      .in_x       (cordic_x),
      .in_z       (cordic_z),
      .pwm_period (pwm_period_ff),
      .out_valid  (rsp_valid),
      .compare_a  (rsp_compare_a),
      .compare_b  (rsp_compare_b),
      .compare_c  (rsp_compare_c)
   );

   // compare values never pass the period
   a_cmp_in_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_compare_a <= pwm_period_ff) && (rsp_compare_b <= pwm_period_ff)
                    && (rsp_compare_c <= pwm_period_ff))
      else $error("compare value beyond pwm period");

   // the cordic x output stays in the right half plane
   a_cordic_x_pos: assert property (@(posedge clock) disable iff (reset)
      cordic_valid |-> !cordic_x[XY_BITS-1])
      else $error("cordic length went negative");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

>>> hw/rtl/svc_cordic.sv
// ----------------------------------------------------------------------------
// svc_cordic
// operand select and pipelined vectoring cordic, one iteration per stage
// ----------------------------------------------------------------------------
module svc_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic                             operation,
   input  logic [15:0]                      rotor_angle,
   input  logic signed [15:0]               vec_alpha,
   input  logic signed [15:0]               vec_beta,
   input  logic signed [15:0]               d_demand,
   input  logic signed [15:0]               q_demand,
   output logic                             out_valid,
   output logic signed [svc_pkg::XY_BITS-1:0] out_x,
   output logic [svc_pkg::Z_BITS-1:0]       out_z
);
   import svc_pkg::*;

   logic                      valid_ff [0:CORDIC_STAGES];
   logic signed [XY_BITS-1:0] x_ff     [0:CORDIC_STAGES];
   logic signed [XY_BITS-1:0] y_ff     [0:CORDIC_STAGES];
   logic [Z_BITS-1:0]         z_ff     [0:CORDIC_STAGES];

   logic signed [15:0]        sel_x;
   logic signed [15:0]        sel_y;
   logic signed [XY_BITS-1:0] x0_in;
   logic signed [XY_BITS-1:0] y0_in;
   logic [Z_BITS-1:0]         z0_in;
   logic signed [XY_BITS-1:0] gx;
   logic signed [XY_BITS-1:0] gy;
   logic [Z_BITS-1:0]         gz;

   // operand select, guard bits, fold into right half plane
   always_comb begin
      sel_x = (operation == OP_DIRECT) ? vec_alpha : d_demand;
      sel_y = (operation == OP_DIRECT) ? vec_beta  : q_demand;
      gz    = (operation == OP_DIRECT) ? '0 : {rotor_angle, (Z_BITS-16)'(0)};
      gx    = XY_BITS'(sel_x) <<< GUARD_BITS;
      gy    = XY_BITS'(sel_y) <<< GUARD_BITS;
      if (gx < 0) begin
         x0_in = -gx;
         y0_in = -gy;
         z0_in = gz + {1'b1, (Z_BITS-1)'(0)};
      end else begin
         x0_in = gx;
         y0_in = gy;
         z0_in = gz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
      end
   end

   // one rotation step per stage
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      logic signed [XY_BITS-1:0] dx;
      logic signed [XY_BITS-1:0] dy;
      logic signed [XY_BITS-1:0] x_in;
      logic signed [XY_BITS-1:0] y_in;
      logic [Z_BITS-1:0]         z_in;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         if (y_ff[i] >= 0) begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + atan_turn(i);
         end else begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - atan_turn(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (en) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STAGES];
   assign out_x     = x_ff[CORDIC_STAGES];
   assign out_z     = z_ff[CORDIC_STAGES];

endmodule

>>> hw/rtl/svc_timing.sv
// ----------------------------------------------------------------------------
// svc_timing
// length scaling, sector split and centred phase compare values
// ----------------------------------------------------------------------------
module svc_timing (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [svc_pkg::XY_BITS-1:0] in_x,
   input  logic [svc_pkg::Z_BITS-1:0]         in_z,
   input  logic [15:0]                        pwm_period,
   output logic                               out_valid,
   output logic [15:0]                        compare_a,
   output logic [15:0]                        compare_b,
   output logic [15:0]                        compare_c
);
   import svc_pkg::*;

   localparam int PROD_BITS = XY_BITS - 1 + 30;
   localparam int MAG_BITS  = PROD_BITS - 30 - GUARD_BITS;

   // stage 1: gain correction and angle rounding
   logic [PROD_BITS-1:0]  gain_prod;
   logic [Z_BITS-1:0]     z_round;
   logic                  v1_ff;
   logic [MAG_BITS-1:0]   mag_ff;
   logic [ANGLE_BITS-1:0] angle_ff;

   always_comb begin
      gain_prod = PROD_BITS'(in_x[XY_BITS-2:0]) * PROD_BITS'(INV_GAIN);
      z_round   = in_z + (Z_BITS'(1) << (31 - ANGLE_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         mag_ff   <= gain_prod[PROD_BITS-1:30+GUARD_BITS];
         angle_ff <= z_round[Z_BITS-1 -: ANGLE_BITS];
      end
   end

   // stage 2: saturate length, on-time, sector and fraction
   logic [LEN_BITS-1:0]   len;
   logic [31:0]           on_prod;
   logic [SIX_BITS-1:0]   six_a;
   logic                  v2_ff;
   logic [15:0]           on_ff;
   logic [2:0]            sector2_ff;
   logic [ANGLE_BITS-1:0] frac_ff;

   always_comb begin
      len     = (mag_ff > MAG_BITS'(FULL_LEN)) ? FULL_LEN : mag_ff[LEN_BITS-1:0];
      on_prod = 32'(pwm_period) * 32'(len);
      six_a   = (SIX_BITS'(angle_ff) << 2) + (SIX_BITS'(angle_ff) << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         on_ff      <= on_prod[30:15];
         sector2_ff <= six_a[SIX_BITS-1 -: 3];
         frac_ff    <= six_a[ANGLE_BITS-1:0];
      end
   end

   // stage 3: dwell times of the two active vectors and the zero-vector offset
   localparam int T_BITS = ANGLE_BITS + 1 + 16;
   logic [T_BITS-1:0] t0_prod;
   logic [T_BITS-1:0] t1_prod;
   logic [15:0]       off_full;
   logic              v3_ff;
   logic [15:0]       t0_ff;
   logic [15:0]       t1_ff;
   logic [15:0]       off_ff;
   logic [2:0]        sector3_ff;

   always_comb begin
      t0_prod  = ((T_BITS'(1) << ANGLE_BITS) - T_BITS'(frac_ff)) * T_BITS'(on_ff);
      t1_prod  = T_BITS'(frac_ff) * T_BITS'(on_ff);
      off_full = (pwm_period - on_ff) >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         t0_ff      <= t0_prod[ANGLE_BITS+15:ANGLE_BITS];
         t1_ff      <= t1_prod[ANGLE_BITS+15:ANGLE_BITS];
         off_ff     <= off_full;
         sector3_ff <= sector2_ff;
      end
   end

   // stage 4: order the vectors and build the compare values
   logic [2:0]  next_sector;
   logic [2:0]  vec1;
   logic [2:0]  vec2;
   logic [15:0] first;
   logic [15:0] second;
   logic [15:0] mid;
   logic [15:0] late;
   logic [15:0] cmp_a_in;
   logic [15:0] cmp_b_in;
   logic [15:0] cmp_c_in;
   logic        rsp_valid_ff;
   logic [15:0] cmp_a_ff;
   logic [15:0] cmp_b_ff;
   logic [15:0] cmp_c_ff;

   always_comb begin
      next_sector = (sector3_ff == LAST_SECTOR) ? 3'd0 : sector3_ff + 3'd1;
      // even sectors own the single-high vector
      if (!sector3_ff[0]) begin
         vec1   = sector3_ff;
         vec2   = next_sector;
         first  = t0_ff;
         second = t1_ff;
      end else begin
         vec1   = next_sector;
         vec2   = sector3_ff;
         first  = t1_ff;
         second = t0_ff;
      end
      mid  = off_ff + first;
      late = mid + second;
      cmp_a_in = HIGH_A[vec1] ? off_ff : (HIGH_A[vec2] ? mid : late);
      cmp_b_in = HIGH_B[vec1] ? off_ff : (HIGH_B[vec2] ? mid : late);
      cmp_c_in = HIGH_C[vec1] ? off_ff : (HIGH_C[vec2] ? mid : late);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v3_ff;
      end
      if (en) begin
         cmp_a_ff <= cmp_a_in;
         cmp_b_ff <= cmp_b_in;
         cmp_c_ff <= cmp_c_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign compare_a = cmp_a_ff;
   assign compare_b = cmp_b_ff;
   assign compare_c = cmp_c_ff;

endmodule
